// ===== rtl/lrc_pkg.sv =====
package lrc_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int COLOR_SHIFT = 8;
  localparam int QDEPTH      = 2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    K_VERT,
    K_HORZ,
    K_DIAG
  } kind_t;

  // one classified, clipped line command
  typedef struct packed {
    kind_t              kind;
    logic [6:0]         lo;     // first step index, already clipped
    logic [6:0]         hi;     // step end (exclusive), already clipped
    logic signed [15:0] fix;    // fixed x (vert), fixed y (horz), y start (diag)
    logic [15:0]        adx;    // |dx|
    logic [15:0]        ady;    // |dy|
    logic [15:0]        k0;     // lo minus x start (diag)
    logic               neg;    // slope sign
    logic [23:0]        color;
  } cmd_t;

endpackage

// ===== rtl/lrc_front.sv =====
module lrc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [87:0]        in_tdata,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               push_valid,
  input  logic               push_ready,
  output lrc_pkg::cmd_t      push_cmd,
  output logic [6:0]         width,
  output logic [6:0]         height
);
  import lrc_pkg::*;

  logic [6:0]         width_r, height_r;
  logic [6:0]         cfg_w_clamp, cfg_h_clamp;
  logic signed [16:0] xa, ya, xb, yb, dx, dy, w_s, h_s;
  logic signed [16:0] vmin, vmax, hmin, hmax, xs, ys, xe;
  logic signed [16:0] lo_s, hi_s, k0_s;
  logic               nonempty;
  kind_t              kind;

  // register writes, clamped to the legal range
  always_comb begin
    if (cfg_data == 7'd0) cfg_w_clamp = 7'd1;
    else if (cfg_data > 7'(MAX_WIDTH)) cfg_w_clamp = 7'(MAX_WIDTH);
    else cfg_w_clamp = cfg_data;
    if (cfg_data == 7'd0) cfg_h_clamp = 7'd1;
    else if (cfg_data > 7'(MAX_HEIGHT)) cfg_h_clamp = 7'(MAX_HEIGHT);
    else cfg_h_clamp = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'(MAX_WIDTH);
      height_r <= 7'(MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_w_clamp;
      else if (cfg_index == REG_HEIGHT) height_r <= cfg_h_clamp;
    end
  end

  assign width  = width_r;
  assign height = height_r;

  // classify and clip
  always_comb begin
    xa  = 17'(signed'(in_tdata[15:0]));
    ya  = 17'(signed'(in_tdata[31:16]));
    xb  = 17'(signed'(in_tdata[47:32]));
    yb  = 17'(signed'(in_tdata[63:48]));
    dx  = xb - xa;
    dy  = yb - ya;
    w_s = signed'({10'd0, width_r});
    h_s = signed'({10'd0, height_r});
    vmin = (ya < yb) ? ya : yb;
    vmax = (ya < yb) ? yb : ya;
    hmin = (xa < xb) ? xa : xb;
    hmax = (xa < xb) ? xb : xa;
    xs = (xa > xb) ? xb : xa;
    ys = (xa > xb) ? yb : ya;
    xe = (xa > xb) ? xa : xb;
    k0_s = '0;
    if (dx == 17'sd0) begin
      kind = K_VERT;
      lo_s = (vmin < 0) ? 17'sd0 : vmin;
      hi_s = (vmax > h_s) ? h_s : vmax;
      nonempty = (xa >= 0) && (xa < w_s) && (lo_s < hi_s);
    end else if (dy == 17'sd0) begin
      kind = K_HORZ;
      lo_s = (hmin < 0) ? 17'sd0 : hmin;
      hi_s = (hmax > w_s) ? w_s : hmax;
      nonempty = (ya >= 0) && (ya < h_s) && (lo_s < hi_s);
    end else begin
      kind = K_DIAG;
      lo_s = (xs < 0) ? 17'sd0 : xs;
      hi_s = (xe > w_s) ? w_s : xe;
      k0_s = lo_s - xs;
      nonempty = (lo_s < hi_s);
    end
  end

  always_comb begin
    push_cmd.kind  = kind;
    push_cmd.lo    = lo_s[6:0];
    push_cmd.hi    = hi_s[6:0];
    unique case (kind)
      K_VERT:  push_cmd.fix = xa[15:0];
      K_HORZ:  push_cmd.fix = ya[15:0];
      default: push_cmd.fix = ys[15:0];
    endcase
    push_cmd.adx   = dx[16] ? 16'(-dx) : dx[15:0];
    push_cmd.ady   = dy[16] ? 16'(-dy) : dy[15:0];
    push_cmd.k0    = k0_s[15:0];
    push_cmd.neg   = dx[16] ^ dy[16];
    push_cmd.color = in_tdata[87:64];
  end

  // lines with nothing on the canvas are taken and dropped
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && nonempty;

endmodule

// ===== rtl/lrc_fifo.sv =====
module lrc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  lrc_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output lrc_pkg::cmd_t rd_cmd
);
  import lrc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_cmd;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/lrc_back.sv =====
module lrc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  lrc_pkg::cmd_t cmd,
  input  logic [6:0]    width,
  input  logic [6:0]    height,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [11:0]   out_addr,
  output logic [31:0]   out_word,
  output logic          out_last
);
  import lrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DIVQ,
    S_STEP,
    S_FLUSH
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [6:0]         i_r;
  logic [4:0]         cnt_r;
  logic [31:0]        dvd_r;
  logic [15:0]        rem_r;
  logic [16:0]        a_r;
  logic [15:0]        r_r, qd_r, rd_r;
  logic               pend_v_r;
  logic [11:0]        pend_addr_r;
  logic               out_v_r, out_last_r;
  logic [11:0]        out_addr_r;
  logic [23:0]        out_color_r;

  logic [16:0]        rem_sh, r2;
  logic               div_ge, r_ge;
  logic [15:0]        rem_n;
  logic [31:0]        dvd_n;
  logic signed [17:0] j;
  logic [5:0]         cx, cy;
  logic               cvalid;
  logic [11:0]        caddr;
  logic               out_free;
  logic               out_load;

  // one restoring divide step by |dx|
  always_comb begin
    rem_sh = {rem_r, dvd_r[31]};
    div_ge = (rem_sh >= {1'b0, cmd_r.adx});
    rem_n  = div_ge ? 16'(rem_sh - {1'b0, cmd_r.adx}) : rem_sh[15:0];
    dvd_n  = {dvd_r[30:0], div_ge};
  end

  // remainder step of the incremental quotient
  always_comb begin
    r2   = {1'b0, r_r} + {1'b0, rd_r};
    r_ge = (r2 >= {1'b0, cmd_r.adx});
  end

  // candidate pixel for the current step
  always_comb begin
    j = cmd_r.neg ? (18'(signed'(cmd_r.fix)) - signed'({1'b0, a_r}))
                  : (18'(signed'(cmd_r.fix)) + signed'({1'b0, a_r}));
    unique case (cmd_r.kind)
      K_VERT: begin
        cx = cmd_r.fix[5:0];
        cy = i_r[5:0];
        cvalid = 1'b1;
      end
      K_HORZ: begin
        cx = i_r[5:0];
        cy = cmd_r.fix[5:0];
        cvalid = 1'b1;
      end
      default: begin
        cx = i_r[5:0];
        cy = j[5:0];
        cvalid = (j >= 0) && (j < signed'({11'd0, height}));
      end
    endcase
    caddr = 12'(cx) + 12'(cy) * 12'(width);
  end

  assign out_free  = !out_v_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE);

  // output register loads on a pushed-out pixel or on the final flush
  always_comb begin
    unique case (state_r)
      S_STEP:  out_load = cvalid && pend_v_r && out_free;
      S_FLUSH: out_load = pend_v_r && out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            i_r   <= cmd.lo;
            state_r <= (cmd.kind == K_DIAG) ? S_MUL : S_STEP;
          end
        end
        S_MUL: begin
          dvd_r <= cmd_r.ady * cmd_r.k0;
          rem_r <= '0;
          cnt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 5'd31) begin
            a_r   <= {1'b0, dvd_n[15:0]};
            r_r   <= rem_n;
            dvd_r <= {cmd_r.ady, 16'd0};
            rem_r <= '0;
            cnt_r <= '0;
            state_r <= S_DIVQ;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            dvd_r <= dvd_n;
            rem_r <= rem_n;
          end
        end
        S_DIVQ: begin
          cnt_r <= cnt_r + 1'b1;
          dvd_r <= dvd_n;
          rem_r <= rem_n;
          if (cnt_r == 5'd15) begin
            qd_r <= dvd_n[15:0];
            rd_r <= rem_n;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          // a found pixel pushes the held one out; stall if output is busy
          if (!(cvalid && pend_v_r && !out_free)) begin
            if (cvalid) begin
              if (pend_v_r) begin
                out_addr_r  <= pend_addr_r;
                out_last_r  <= 1'b0;
                out_color_r <= cmd_r.color;
              end
              pend_v_r    <= 1'b1;
              pend_addr_r <= caddr;
            end
            i_r <= i_r + 1'b1;
            r_r <= r_ge ? 16'(r2 - {1'b0, cmd_r.adx}) : r2[15:0];
            a_r <= a_r + {1'b0, qd_r} + {16'd0, r_ge};
            if (i_r == cmd_r.hi - 1'b1) state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_addr_r  <= pend_addr_r;
            out_last_r  <= 1'b1;
            out_color_r <= cmd_r.color;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_addr  = out_addr_r;
  assign out_word  = {out_color_r, {COLOR_SHIFT{1'b0}}};
  assign out_last  = out_last_r;

endmodule

// ===== rtl/line_rasterizer_clipped.sv =====
// Channel   Dir  Word
// in_       in   88-bit line command
// out_      out  48-bit framebuffer write, tlast on a line's final write
// cfg_      in   register write, index 0 width, index 1 height
//
// Flow: axis-aligned lines go straight to stepping; sloped lines first run a
// multiply and then a divide of 32 + 16 steps in the one-bit-per-cycle divider
// before stepping.
// Reset: synchronous, active low; canvas returns to 64 x 64.
// A two-word queue lets commands be taken while the stepper works; the
// stepper holds when the output word is not taken.
module line_rasterizer_clipped (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // x_start, y_start, x_end, y_end, color_rgb
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_address, pixel_word, zero pad
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import lrc_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  cmd_t       push_cmd, pop_cmd;
  logic [6:0] width, height;
  logic [11:0] addr;
  logic [31:0] word;

  lrc_front u_front (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .push_valid, .push_ready, .push_cmd,
    .width, .height
  );

  lrc_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_cmd(push_cmd),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_cmd(pop_cmd)
  );

  lrc_back u_back (
    .clk, .rst_n,
    .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd(pop_cmd),
    .width, .height,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_addr(addr), .out_word(word), .out_last(out_tlast)
  );

  assign out_tdata = {4'd0, word, addr};

endmodule
